### hw/rtl/ssrb_pkg.sv
// ---------------------------------------------------------------------------
// ssrb_pkg: shared constants for the sound source range/bearing table
// Sizes, item codes, angle scaling and the CORDIC angle steps.
// ---------------------------------------------------------------------------
package ssrb_pkg;

	localparam int MAX_SOURCES = 16;
	localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
	localparam int IDX_W       = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;
	localparam int ENTRY_W     = 96;

	// item modes
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_EXPIRE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// degrees = rad * DEG_SCALE / (PI_MICRO * 2^k)
	localparam logic [31:0] DEG_SCALE = 32'd180000000;
	localparam logic [31:0] PI_MICRO  = 32'd3141592;

	// floor(n / PI_MICRO) = (n * PI_RECIP) >> RECIP_SHIFT, exact for n below 2^31
	localparam int          RECIP_SHIFT = 53;
	localparam logic [31:0] PI_RECIP    =
		32'((64'd1 << RECIP_SHIFT) / 64'(PI_MICRO) + 64'd1);

	localparam int CORDIC_STEPS = 31;

	// atan(2^-i) in units of 2^-30 rad
	function automatic logic [30:0] atan_step(input logic [4:0] i);
		logic [30:0] a;
		begin
			case (i)
				5'd0: a = 31'd843314857;
				5'd1: a = 31'd497837829;
				5'd2: a = 31'd263043837;
				5'd3: a = 31'd133525159;
				5'd4: a = 31'd67021687;
				5'd5: a = 31'd33543516;
				5'd6: a = 31'd16775851;
				5'd7: a = 31'd8388437;
				5'd8: a = 31'd4194283;
				5'd9: a = 31'd2097149;
				default: a = 31'd1 << (5'd30 - i);
			endcase
			return a;
		end
	endfunction

endpackage

### hw/rtl/ssrb_if.sv
// ---------------------------------------------------------------------------
// ssrb_if: channel interfaces of the sound source table
// Command, result and configuration channels with valid/ready.
// ---------------------------------------------------------------------------
interface ssrb_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [19:0] yaw_rad;
	logic [31:0]        time_value;
	logic [4:0]         want_count;

	modport source (output valid, mode, pos_x, pos_y, yaw_rad, time_value, want_count,
		input ready);
	modport sink (input valid, mode, pos_x, pos_y, yaw_rad, time_value, want_count,
		output ready);
endinterface

interface ssrb_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] distance;
	logic [8:0]  bearing_deg;
	logic [15:0] frequency;
	logic [4:0]  source_count;
	logic [1:0]  status;
	logic        last;

	modport source (output valid, distance, bearing_deg, frequency, source_count, status,
		last, input ready);
	modport sink (input valid, distance, bearing_deg, frequency, source_count, status,
		last, output ready);
endinterface

interface ssrb_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hw/rtl/ssrb_ram.sv
// ---------------------------------------------------------------------------
// ssrb_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module ssrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/ssrb_sqrt.sv
// ---------------------------------------------------------------------------
// ssrb_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module ssrb_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  step_q;
	logic [63:0] n_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	// one bit pair per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			n_q    <= '0;
			res_q  <= '0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
			n_q    <= radicand;
			res_q  <= '0;
			bit_q  <= 64'd1 << 62;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q  <= bit_q >> 2;
			step_q <= step_q + 5'd1;
			if (step_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];
endmodule

### hw/rtl/ssrb_cordic.sv
// ---------------------------------------------------------------------------
// ssrb_cordic: vectoring CORDIC arctangent
// Normalizes both magnitudes, then 31 rotation steps, one per cycle.
// ---------------------------------------------------------------------------
module ssrb_cordic (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] ax,
	input  logic [31:0] ay,
	output logic        done,
	output logic [30:0] angle
);
	typedef enum logic [1:0] {
		C_IDLE,
		C_NORM,
		C_ROT
	} cstate_t;

	cstate_t            state_q;
	logic               done_q;
	logic [4:0]         i_q;
	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [32:0] z_q;
	logic [31:0]        mag_or;
	logic signed [35:0] xs;
	logic signed [35:0] ys;
	logic signed [32:0] a;

	assign mag_or = x_q[31:0] | y_q[31:0];
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign a      = signed'({2'b00, ssrb_pkg::atan_step(i_q)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			i_q     <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (start) begin
						x_q     <= signed'({4'b0, ax});
						y_q     <= signed'({4'b0, ay});
						done_q  <= 1'b0;
						state_q <= C_NORM;
					end
				end
				// scale up until the larger magnitude has bit 31 set
				C_NORM: begin
					if (mag_or[31:23] == '0) begin
						x_q <= x_q <<< 8;
						y_q <= y_q <<< 8;
					end else if (!mag_or[31]) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						i_q     <= '0;
						z_q     <= '0;
						state_q <= C_ROT;
					end
				end
				// drive y toward zero, accumulate angle
				C_ROT: begin
					if (!y_q[35]) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + a;
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - a;
					end
					i_q <= i_q + 5'd1;
					if (i_q == 5'(ssrb_pkg::CORDIC_STEPS - 1)) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done  = done_q;
	assign angle = z_q[32] ? '0 : z_q[30:0];
endmodule

### hw/rtl/ssrb_div.sv
// ---------------------------------------------------------------------------
// ssrb_div: divider by the fixed pi constant
// 9-bit quotient of num / 3141592 by reciprocal multiplication.
// ---------------------------------------------------------------------------
module ssrb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	output logic        done,
	output logic [8:0]  quo
);
	logic        busy_q;
	logic        done_q;
	logic [31:0] num_q;
	logic [63:0] prod_q;

	// latch the numerator, then one multiply by the scaled reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			num_q  <= '0;
			prod_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			num_q  <= num;
		end else if (busy_q) begin
			prod_q <= num_q * ssrb_pkg::PI_RECIP;
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = prod_q[ssrb_pkg::RECIP_SHIFT +: 9];
endmodule

### hw/rtl/sound_source_range_bearing_table.sv
// ---------------------------------------------------------------------------
// sound_source_range_bearing_table: source table with range/bearing query
// Sources live in one RAM, oldest first; add, expire and query commands.
//
//   channel | dir | moves
//   --------+-----+---------------------------------------------
//   cmd     | in  | one command item (add, expire, query)
//   rsp     | out | result items, last marks the final one
//   cfg     | in  | frequency bound register write
//
// Add and other modes answer with one result. Expire walks the table, one
// entry per cycle. Query first turns the heading into degrees with the
// divide, then per source runs the 32-step square root and, off axis,
// normalize plus 31 CORDIC steps and the divide. No clearing pass after reset.
// A result waits in S_EMIT while the output register is held. One command
// at a time; the next is taken while the last result still waits in the
// output register.
// ---------------------------------------------------------------------------
module sound_source_range_bearing_table (
	input  logic        clk,
	input  logic        arst_n,
	ssrb_cmd_if.sink    cmd,
	ssrb_rsp_if.source  rsp,
	ssrb_cfg_if.sink    cfg
);
	typedef enum logic [4:0] {
		S_IDLE,
		S_EXP,
		S_YMUL,
		S_YDIV,
		S_YWAIT,
		S_RD,
		S_DIFF,
		S_SQA,
		S_SQB,
		S_SUM,
		S_AWAIT,
		S_ZMUL,
		S_ZDIV,
		S_ZWAIT,
		S_BRG,
		S_SQW,
		S_EMIT
	} state_t;

	localparam int CNT_W = ssrb_pkg::CNT_W;
	localparam int IDX_W = ssrb_pkg::IDX_W;

	state_t                    state_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;
	logic [CNT_W-1:0]          wr_q;
	logic [CNT_W-1:0]          n_q;
	logic [15:0]               freq_q;
	logic signed [31:0]        lx_q;
	logic signed [31:0]        ly_q;
	logic [31:0]               tv_q;
	logic [19:0]               yaw_mag_q;
	logic                      yaw_neg_q;
	logic [8:0]                ydeg_q;
	logic signed [32:0]        dx_q;
	logic signed [32:0]        dy_q;
	logic [31:0]               ax_q;
	logic [31:0]               ay_q;
	logic [63:0]               sa_q;
	logic [63:0]               prod_q;
	logic                      sat_q;
	logic [6:0]                deg_q;
	logic                      is_query_q;
	logic [31:0]               pend_dist_q;
	logic [8:0]                pend_brg_q;
	logic [1:0]                pend_status_q;
	logic                      pend_last_q;
	logic                      rsp_valid_q;
	logic [31:0]               rsp_dist_q;
	logic [8:0]                rsp_brg_q;
	logic [15:0]               rsp_freq_q;
	logic [4:0]                rsp_cnt_q;
	logic [1:0]                rsp_status_q;
	logic                      rsp_last_q;

	logic                      cmd_fire;
	logic                      full;
	logic [31:0]               mul_a;
	logic [31:0]               mul_b;
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [ssrb_pkg::ENTRY_W-1:0] ram_wdata;
	logic [IDX_W-1:0]          ram_raddr;
	logic [ssrb_pkg::ENTRY_W-1:0] ram_rdata;
	logic                      keep;
	logic [CNT_W-1:0]          idx_inc;
	logic [ssrb_pkg::CMP_W-1:0] want_ext;
	logic [ssrb_pkg::CMP_W-1:0] cnt_ext;
	logic [CNT_W-1:0]          n_new;
	logic [31:0]               abs_dx;
	logic [31:0]               abs_dy;
	logic [64:0]               sum;
	logic                      need_cordic;
	logic                      sqrt_done;
	logic [31:0]               sqrt_root;
	logic                      cor_done;
	logic [30:0]               cor_angle;
	logic                      div_start;
	logic [31:0]               div_num;
	logic                      div_done;
	logic [8:0]                div_quo;
	logic [8:0]                yq_mod;
	logic signed [10:0]        ang;
	logic signed [10:0]        brg;
	logic                      slot_free;

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign full      = (count_q >= CNT_W'(ssrb_pkg::MAX_SOURCES));
	assign idx_inc   = idx_q + 1'b1;
	assign keep      = (ram_rdata[95:64] > tv_q);
	assign slot_free = !rsp_valid_q || rsp.ready;

	// query length
	assign want_ext = ssrb_pkg::CMP_W'(cmd.want_count);
	assign cnt_ext  = ssrb_pkg::CMP_W'(count_q);
	assign n_new    = (want_ext < cnt_ext) ? CNT_W'(want_ext) : count_q;

	// frequency register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			freq_q <= cfg.data;
		end
	end

	// table RAM: {end, y, x}
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = {cmd.time_value, cmd.pos_y, cmd.pos_x};
		ram_raddr = idx_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				ram_we    = cmd_fire && (cmd.mode == ssrb_pkg::MODE_ADD) && !full;
				ram_raddr = '0;
			end
			S_EXP: begin
				ram_we    = keep;
				ram_waddr = wr_q[IDX_W-1:0];
				ram_wdata = ram_rdata;
				ram_raddr = idx_inc[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	ssrb_ram #(
		.WIDTH (ssrb_pkg::ENTRY_W),
		.DEPTH (ssrb_pkg::MAX_SOURCES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// offset magnitudes
	assign abs_dx = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
	assign abs_dy = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];

	// shared multiplier operands
	always_comb begin
		case (state_q)
			S_YMUL: begin
				mul_a = 32'(yaw_mag_q);
				mul_b = ssrb_pkg::DEG_SCALE;
			end
			S_SQA: begin
				mul_a = abs_dx;
				mul_b = abs_dx;
			end
			S_ZMUL: begin
				mul_a = 32'(cor_angle);
				mul_b = ssrb_pkg::DEG_SCALE;
			end
			default: begin
				mul_a = ay_q;
				mul_b = ay_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// arithmetic units
	assign sum         = {1'b0, sa_q} + {1'b0, prod_q};
	assign need_cordic = (dx_q != '0) && (dy_q != '0);
	assign div_start   = (state_q == S_YDIV) || (state_q == S_ZDIV);
	assign div_num     = (state_q == S_YDIV) ? 32'(prod_q[46:16]) : 32'(prod_q[58:30]);

	ssrb_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SUM),
		.radicand (sum[63:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	ssrb_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  ((state_q == S_SUM) && need_cordic),
		.ax     (ax_q),
		.ay     (ay_q),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	ssrb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.done   (div_done),
		.quo    (div_quo)
	);

	// heading in degrees, brought into 0..359
	assign yq_mod = (div_quo >= 9'd360) ? div_quo - 9'd360 : div_quo;

	// bearing from quadrant, angle and heading
	always_comb begin
		ang = signed'({4'b0, deg_q});
		if ((!dy_q[32] && dy_q != '0) != !dx_q[32]) begin
			ang = -ang;
		end
		ang = ang + (dx_q[32] ? 11'sd180 : 11'sd360);
		if (ang >= 11'sd360) begin
			ang = ang - 11'sd360;
		end
		brg = 11'sd360 - signed'({2'b0, ydeg_q}) + ang;
		if (brg >= 11'sd360) begin
			brg = brg - 11'sd360;
		end
		if (dx_q == '0 && dy_q == '0) begin
			brg = '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			wr_q          <= '0;
			n_q           <= '0;
			lx_q          <= '0;
			ly_q          <= '0;
			tv_q          <= '0;
			yaw_mag_q     <= '0;
			yaw_neg_q     <= 1'b0;
			ydeg_q        <= '0;
			dx_q          <= '0;
			dy_q          <= '0;
			ax_q          <= '0;
			ay_q          <= '0;
			sa_q          <= '0;
			sat_q         <= 1'b0;
			deg_q         <= '0;
			is_query_q    <= 1'b0;
			pend_dist_q   <= '0;
			pend_brg_q    <= '0;
			pend_status_q <= ssrb_pkg::ST_OK;
			pend_last_q   <= 1'b0;
			rsp_valid_q   <= 1'b0;
			rsp_dist_q    <= '0;
			rsp_brg_q     <= '0;
			rsp_freq_q    <= '0;
			rsp_cnt_q     <= '0;
			rsp_status_q  <= ssrb_pkg::ST_OK;
			rsp_last_q    <= 1'b0;
		end else begin
			// output valid: set on emit, cleared once taken
			if (state_q == S_EMIT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						lx_q          <= cmd.pos_x;
						ly_q          <= cmd.pos_y;
						tv_q          <= cmd.time_value;
						yaw_neg_q     <= cmd.yaw_rad[19];
						yaw_mag_q     <= cmd.yaw_rad[19] ? 20'(-cmd.yaw_rad) : cmd.yaw_rad;
						idx_q         <= '0;
						wr_q          <= '0;
						is_query_q    <= 1'b0;
						pend_dist_q   <= '0;
						pend_brg_q    <= '0;
						pend_status_q <= ssrb_pkg::ST_OK;
						pend_last_q   <= 1'b1;
						state_q       <= S_EMIT;
						case (cmd.mode)
							ssrb_pkg::MODE_ADD: begin
								if (full) begin
									pend_status_q <= ssrb_pkg::ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							ssrb_pkg::MODE_EXPIRE: begin
								if (count_q != '0) begin
									state_q <= S_EXP;
								end
							end
							ssrb_pkg::MODE_QUERY: begin
								if (count_q == '0) begin
									pend_status_q <= ssrb_pkg::ST_EMPTY;
								end else if (n_new == '0) begin
									state_q <= S_IDLE;
								end else begin
									n_q        <= n_new;
									is_query_q <= 1'b1;
									state_q    <= S_YMUL;
								end
							end
							default: ;
						endcase
					end
				end
				// compact survivors toward the head, read runs one ahead
				S_EXP: begin
					wr_q  <= wr_q + CNT_W'(keep);
					idx_q <= idx_inc;
					if (idx_inc == count_q) begin
						count_q <= wr_q + CNT_W'(keep);
						state_q <= S_EMIT;
					end
				end
				S_YMUL:  state_q <= S_YDIV;
				S_YDIV:  state_q <= S_YWAIT;
				S_YWAIT: begin
					if (div_done) begin
						ydeg_q  <= (yaw_neg_q && yq_mod != '0) ? 9'd360 - yq_mod : yq_mod;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_DIFF;
				// offsets from the listener
				S_DIFF: begin
					dx_q    <= {ram_rdata[31], ram_rdata[31:0]} - {lx_q[31], lx_q};
					dy_q    <= {ram_rdata[63], ram_rdata[63:32]} - {ly_q[31], ly_q};
					state_q <= S_SQA;
				end
				S_SQA: begin
					ax_q    <= abs_dx;
					ay_q    <= abs_dy;
					state_q <= S_SQB;
				end
				S_SQB: begin
					sa_q    <= prod_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sat_q   <= sum[64];
					deg_q   <= (dy_q == '0) ? 7'd0 : 7'd90;
					state_q <= need_cordic ? S_AWAIT : S_BRG;
				end
				S_AWAIT: begin
					if (cor_done) begin
						state_q <= S_ZMUL;
					end
				end
				S_ZMUL:  state_q <= S_ZDIV;
				S_ZDIV:  state_q <= S_ZWAIT;
				S_ZWAIT: begin
					if (div_done) begin
						deg_q   <= (div_quo > 9'd90) ? 7'd90 : div_quo[6:0];
						state_q <= S_BRG;
					end
				end
				S_BRG: begin
					pend_brg_q <= brg[8:0];
					state_q    <= S_SQW;
				end
				S_SQW: begin
					if (sqrt_done) begin
						pend_dist_q <= sat_q ? 32'hFFFF_FFFF : sqrt_root;
						pend_last_q <= (idx_inc == n_q);
						state_q     <= S_EMIT;
					end
				end
				// hand the result to the output register
				S_EMIT: begin
					if (slot_free) begin
						rsp_dist_q   <= pend_dist_q;
						rsp_brg_q    <= pend_brg_q;
						rsp_freq_q   <= is_query_q ? freq_q : 16'd0;
						rsp_cnt_q    <= 5'(count_q);
						rsp_status_q <= pend_status_q;
						rsp_last_q   <= pend_last_q;
						if (is_query_q && !pend_last_q) begin
							idx_q   <= idx_inc;
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.distance     = rsp_dist_q;
	assign rsp.bearing_deg  = rsp_brg_q;
	assign rsp.frequency    = rsp_freq_q;
	assign rsp.source_count = rsp_cnt_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.last         = rsp_last_q;
endmodule
